/* hdl/sva_pkg.sv */
`timescale 1ns / 1ps
package sva_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int INDEX_WIDTH = 16;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 64;
   localparam int VAL_W       = 32;
   localparam int ENTRY_W     = KEY_W + 2 * VAL_W;
   localparam logic [VAL_W-1:0] VAL_MAX      = '1;
   localparam logic [VAL_W-1:0] SCALE_RESET  = 32'h0001_0000;
   localparam logic [47:0]      ORDER_FLIP   = 48'h8000_8000_8000;
   localparam logic             CMD_ADD      = 1'b0;
   localparam logic             CMD_DRAIN    = 1'b1;

   typedef struct packed {
      logic load_item;
      logic idx_clear;
      logic idx_inc;
      logic idx_dec;
      logic idx_load_cnt;
      logic pos_load;
      logic rd_en;
      logic rd_prev;
      logic wr_acc;
      logic wr_shift;
      logic wr_new;
      logic cnt_inc;
      logic cnt_clear;
      logic mul_load;
      logic hold_load;
      logic hold_clear;
      logic out_hold;
      logic out_last;
      logic out_empty;
      logic out_ovf;
   } sva_cmd_type;

   typedef struct packed {
      logic match;
      logic greater;
      logic idx_last;
      logic prev_is_pos;
      logic cnt_zero;
      logic full;
      logic count_pos;
      logic hold_valid;
      logic out_free;
   } sva_status_type;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_SRD  = 11'b000_0000_0010,
      ST_SCMP = 11'b000_0000_0100,
      ST_SHRD = 11'b000_0000_1000,
      ST_SHWR = 11'b000_0001_0000,
      ST_INS  = 11'b000_0010_0000,
      ST_OVF  = 11'b000_0100_0000,
      ST_DRD  = 11'b000_1000_0000,
      ST_DCMP = 11'b001_0000_0000,
      ST_DMUL = 11'b010_0000_0000,
      ST_DFIN = 11'b100_0000_0000
   } sva_state_type;

   // sign-extend the low INDEX_WIDTH bits of a key component
   function automatic logic [15:0] norm_index(input logic [15:0] raw);
      logic signed [INDEX_WIDTH-1:0] low;
      low = raw[INDEX_WIDTH-1:0];
      return 16'(low);
   endfunction

   function automatic logic [VAL_W-1:0] sat_add(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
   endfunction

   function automatic logic [VAL_W-1:0] sat_scale(input logic [2*VAL_W-1:0] p);
      return (p[2*VAL_W-1:VAL_W+16] != '0) ? VAL_MAX : p[VAL_W+15:16];
   endfunction

endpackage

/* hdl/sva_ram.sv */
`timescale 1ns / 1ps
module sva_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/sva_ctrl.sv */
`timescale 1ns / 1ps
module sva_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_cmd,
   output logic                    req_stall,
   input  sva_pkg::sva_status_type status,
   output sva_pkg::sva_cmd_type    cmd
);

   sva_pkg::sva_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sva_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != sva_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         sva_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               cmd.idx_clear = 1'b1;
               if (req_cmd == sva_pkg::CMD_DRAIN) begin
                  state_in = status.cnt_zero ? sva_pkg::ST_DFIN : sva_pkg::ST_DRD;
               end else begin
                  state_in = status.cnt_zero ? sva_pkg::ST_INS : sva_pkg::ST_SRD;
               end
            end
         end
         sva_pkg::ST_SRD: begin
            cmd.rd_en = 1'b1;
            state_in  = sva_pkg::ST_SCMP;
         end
         sva_pkg::ST_SCMP: begin
            if (status.match) begin
               cmd.wr_acc = 1'b1;
               state_in   = sva_pkg::ST_IDLE;
            end else if (status.greater || status.idx_last) begin
               if (status.full) begin
                  state_in = sva_pkg::ST_OVF;
               end else begin
                  cmd.pos_load     = 1'b1;
                  cmd.idx_load_cnt = 1'b1;
                  state_in = status.greater ? sva_pkg::ST_SHRD : sva_pkg::ST_INS;
               end
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = sva_pkg::ST_SRD;
            end
         end
         sva_pkg::ST_SHRD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_prev = 1'b1;
            state_in    = sva_pkg::ST_SHWR;
         end
         sva_pkg::ST_SHWR: begin
            cmd.wr_shift = 1'b1;
            cmd.idx_dec  = 1'b1;
            state_in     = status.prev_is_pos ? sva_pkg::ST_INS : sva_pkg::ST_SHRD;
         end
         sva_pkg::ST_INS: begin
            cmd.wr_new  = 1'b1;
            cmd.cnt_inc = 1'b1;
            state_in    = sva_pkg::ST_IDLE;
         end
         sva_pkg::ST_OVF: begin
            if (status.out_free) begin
               cmd.out_ovf = 1'b1;
               state_in    = sva_pkg::ST_IDLE;
            end
         end
         sva_pkg::ST_DRD: begin
            cmd.rd_en = 1'b1;
            state_in  = sva_pkg::ST_DCMP;
         end
         sva_pkg::ST_DCMP: begin
            if (status.count_pos) begin
               cmd.mul_load = 1'b1;
               state_in     = sva_pkg::ST_DMUL;
            end else if (status.idx_last) begin
               state_in = sva_pkg::ST_DFIN;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in    = sva_pkg::ST_DRD;
            end
         end
         sva_pkg::ST_DMUL: begin
            if (!status.hold_valid || status.out_free) begin
               cmd.out_hold  = status.hold_valid;
               cmd.hold_load = 1'b1;
               if (status.idx_last) begin
                  state_in = sva_pkg::ST_DFIN;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = sva_pkg::ST_DRD;
               end
            end
         end
         sva_pkg::ST_DFIN: begin
            if (status.out_free) begin
               cmd.out_hold   = status.hold_valid;
               cmd.out_last   = 1'b1;
               cmd.out_empty  = !status.hold_valid;
               cmd.hold_clear = 1'b1;
               cmd.cnt_clear  = 1'b1;
               state_in       = sva_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sva_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/sva_dpath.sv */
`timescale 1ns / 1ps
module sva_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  sva_pkg::sva_cmd_type    cmd,
   output sva_pkg::sva_status_type status,
   input  logic                    csr_wr_en,
   input  logic [31:0]             csr_wr_data,
   input  logic [15:0]             req_slice_id,
   input  logic signed [15:0]      req_x_index,
   input  logic signed [15:0]      req_y_index,
   input  logic signed [15:0]      req_z_index,
   input  logic [31:0]             req_counts_in,
   input  logic [31:0]             req_error_in,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output logic [15:0]             rsp_out_slice,
   output logic signed [15:0]      rsp_out_x,
   output logic signed [15:0]      rsp_out_y,
   output logic signed [15:0]      rsp_out_z,
   output logic [31:0]             rsp_out_counts,
   output logic [31:0]             rsp_out_error,
   output logic                    rsp_empty_flag,
   output logic                    rsp_overflow_flag,
   output logic                    rsp_last
);

   localparam int AW = sva_pkg::ADDR_W;
   localparam int CW = sva_pkg::CNT_W;
   localparam int KW = sva_pkg::KEY_W;
   localparam int VW = sva_pkg::VAL_W;

   logic [VW-1:0] scale_ff;
   logic [KW-1:0] key_ff;
   logic [VW-1:0] cnt_in_ff, err_in_ff;
   logic [CW-1:0] idx_ff, pos_ff, entries_ff;
   logic [KW-1:0] mkey_ff;
   logic [2*VW-1:0] mcnt_ff, merr_ff;
   logic          hold_valid_ff;
   logic [KW-1:0] hkey_ff;
   logic [VW-1:0] hcnt_ff, herr_ff;
   logic          rsp_valid_ff;
   logic [KW-1:0] okey_ff;
   logic [VW-1:0] ocnt_ff, oerr_ff;
   logic          oempty_ff, oovf_ff, olast_ff;

   logic                        wr_en;
   logic [sva_pkg::ENTRY_W-1:0] wr_data, rd_data;
   logic [CW-1:0]               rd_idx;
   logic [KW-1:0]               rd_key;
   logic [VW-1:0]               rd_cnt, rd_err;
   logic [47:0]                 ord_rd, ord_item;
   logic                        out_free, out_load;

   assign rd_idx  = cmd.rd_prev ? idx_ff - CW'(1) : idx_ff;
   assign wr_en   = cmd.wr_acc | cmd.wr_shift | cmd.wr_new;
   assign rd_key  = rd_data[sva_pkg::ENTRY_W-1 -: KW];
   assign rd_cnt  = rd_data[2*VW-1 -: VW];
   assign rd_err  = rd_data[VW-1:0];

   always_comb begin
      wr_data = rd_data;
      if (cmd.wr_acc) begin
         wr_data = {rd_key, sva_pkg::sat_add(rd_cnt, cnt_in_ff),
                    sva_pkg::sat_add(rd_err, err_in_ff)};
      end else if (cmd.wr_new) begin
         wr_data = {key_ff, cnt_in_ff, err_in_ff};
      end
   end

   sva_ram #(
      .WIDTH (sva_pkg::ENTRY_W),
      .DEPTH (sva_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (idx_ff[AW-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_idx[AW-1:0]),
      .rd_data (rd_data)
   );

   // signed key order as an unsigned compare
   assign ord_rd   = rd_key[47:0] ^ sva_pkg::ORDER_FLIP;
   assign ord_item = key_ff[47:0] ^ sva_pkg::ORDER_FLIP;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = cmd.out_hold | cmd.out_empty | cmd.out_ovf;

   assign status.match       = (ord_rd == ord_item);
   assign status.greater     = (ord_rd > ord_item);
   assign status.idx_last    = (idx_ff + CW'(1) == entries_ff);
   assign status.prev_is_pos = (idx_ff - CW'(1) == pos_ff);
   assign status.cnt_zero    = (entries_ff == '0);
   assign status.full        = (entries_ff == CW'(sva_pkg::TABLE_DEPTH));
   assign status.count_pos   = (rd_cnt != '0);
   assign status.hold_valid  = hold_valid_ff;
   assign status.out_free    = out_free;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff      <= sva_pkg::SCALE_RESET;
         entries_ff    <= '0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            scale_ff <= csr_wr_data;
         end
         if (cmd.cnt_clear) begin
            entries_ff <= '0;
         end else if (cmd.cnt_inc) begin
            entries_ff <= entries_ff + CW'(1);
         end
         if (cmd.hold_clear) begin
            hold_valid_ff <= 1'b0;
         end else if (cmd.hold_load) begin
            hold_valid_ff <= 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         key_ff    <= {req_slice_id, sva_pkg::norm_index(req_x_index),
                       sva_pkg::norm_index(req_y_index), sva_pkg::norm_index(req_z_index)};
         cnt_in_ff <= req_counts_in;
         err_in_ff <= req_error_in;
      end
      if (cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.idx_load_cnt) begin
         idx_ff <= entries_ff;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + CW'(1);
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - CW'(1);
      end
      if (cmd.pos_load) begin
         pos_ff <= idx_ff;
      end
      if (cmd.mul_load) begin
         mkey_ff <= rd_key;
         mcnt_ff <= {{VW{1'b0}}, rd_cnt} * {{VW{1'b0}}, scale_ff};
         merr_ff <= {{VW{1'b0}}, rd_err} * {{VW{1'b0}}, scale_ff};
      end
      if (cmd.hold_load) begin
         hkey_ff <= mkey_ff;
         hcnt_ff <= sva_pkg::sat_scale(mcnt_ff);
         herr_ff <= sva_pkg::sat_scale(merr_ff);
      end
      if (out_load) begin
         okey_ff   <= cmd.out_hold ? hkey_ff : '0;
         ocnt_ff   <= cmd.out_hold ? hcnt_ff : '0;
         oerr_ff   <= cmd.out_hold ? herr_ff : '0;
         oempty_ff <= cmd.out_empty;
         oovf_ff   <= cmd.out_ovf;
         olast_ff  <= cmd.out_last | cmd.out_ovf;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_slice     = okey_ff[63:48];
   assign rsp_out_x         = okey_ff[47:32];
   assign rsp_out_y         = okey_ff[31:16];
   assign rsp_out_z         = okey_ff[15:0];
   assign rsp_out_counts    = ocnt_ff;
   assign rsp_out_error     = oerr_ff;
   assign rsp_empty_flag    = oempty_ff;
   assign rsp_overflow_flag = oovf_ff;
   assign rsp_last          = olast_ff;

endmodule

/* hdl/sparse_voxel_accumulator_core.sv */
`timescale 1ns / 1ps
// channel  | direction | ports           | word
// req_     | in        | valid / stall   | cmd, slice id, x/y/z key, counts, error
// rsp_     | out       | valid / stall   | slice, x/y/z, scaled counts/error, flags, last
// csr_     | in        | wr_en / wr_data | volume_scale (Q16.16)
//
// One word at a time. An add walks the sorted table RAM (one read, one write port),
// reading and comparing each entry in turn; an insert before a larger key then shifts
// the tail up, reading and writing one entry per step, before writing the new entry.
// A drain reads and compares each entry and scales and emits those with nonzero counts; stalls add waits.
// Reset (synchronous) empties the table; RAM contents need no clearing.
// One finished word waits in the output register; rsp_stall holds it there.
module sparse_voxel_accumulator_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [31:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [15:0]        req_slice_id,
   input  logic signed [15:0] req_x_index,
   input  logic signed [15:0] req_y_index,
   input  logic signed [15:0] req_z_index,
   input  logic [31:0]        req_counts_in,
   input  logic [31:0]        req_error_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [15:0]        rsp_out_slice,
   output logic signed [15:0] rsp_out_x,
   output logic signed [15:0] rsp_out_y,
   output logic signed [15:0] rsp_out_z,
   output logic [31:0]        rsp_out_counts,
   output logic [31:0]        rsp_out_error,
   output logic               rsp_empty_flag,
   output logic               rsp_overflow_flag,
   output logic               rsp_last
);

   sva_pkg::sva_cmd_type    cmd;
   sva_pkg::sva_status_type status;

   // sequencer: search, shift, insert and drain walk
   sva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table RAM, key compare, scaling multipliers, holding and output words
   sva_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_slice_id      (req_slice_id),
      .req_x_index       (req_x_index),
      .req_y_index       (req_y_index),
      .req_z_index       (req_z_index),
      .req_counts_in     (req_counts_in),
      .req_error_in      (req_error_in),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_out_slice     (rsp_out_slice),
      .rsp_out_x         (rsp_out_x),
      .rsp_out_y         (rsp_out_y),
      .rsp_out_z         (rsp_out_z),
      .rsp_out_counts    (rsp_out_counts),
      .rsp_out_error     (rsp_out_error),
      .rsp_empty_flag    (rsp_empty_flag),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_last          (rsp_last)
   );

   // an accepted word keeps the input closed for at least the next cycle
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input open right after accept");

   // flagged words are single words, so they close their item
   a_flag_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_empty_flag || rsp_overflow_flag) |-> rsp_last)
      else $error("flag word without last");

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_empty_flag && rsp_overflow_flag))
      else $error("empty and overflow together");

endmodule
